// ----- rtl/core/float_sample_split_defines.svh -----
// Assertion helpers used by float_sample_split
`ifndef FLOAT_SAMPLE_SPLIT_DEFINES_SVH
`define FLOAT_SAMPLE_SPLIT_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define FSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fss_pkg.sv -----
package fss_pkg;

	// Result kind carried on tuser
	typedef enum logic [1:0] {
		KIND_FAST    = 2'd0,
		KIND_ESCAPE  = 2'd1,
		KIND_ZERO    = 2'd2,
		KIND_INF_NAN = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_EXPONENT_SPAN  = 2'd0;
	localparam logic [1:0] CFG_FLOOR_EXPONENT = 2'd1;
	localparam logic [1:0] CFG_TOP_EXPONENT   = 2'd2;
	localparam logic [1:0] CFG_SHIFT_TRIM     = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int SAMPLE_W    = 32;
	localparam int RESULT_W    = 88;

	// Fixed symbols and offsets
	localparam logic [8:0]        SYM_INF_NAN   = 9'd278;
	localparam logic [7:0]        EXP_ALL_ONES  = 8'hff;
	localparam logic signed [9:0] EXP_BIAS      = 10'sd127;
	localparam logic signed [9:0] SYM_OFFSET    = 10'sd150;
	localparam logic signed [9:0] MANT_BITS     = 10'sd23;
	localparam logic [4:0]        MANT_BITS_U   = 5'd23;
	localparam logic [8:0]        FLOOR_RESET   = 9'h1e9; // -23

	typedef struct packed {
		logic [4:0]        exponent_span;
		logic signed [8:0] floor_exponent;
		logic signed [8:0] top_exponent;
		logic [4:0]        shift_trim;
	} cfg_t;

	typedef struct packed {
		kind_t             sample_kind;
		logic signed [24:0] int_value;
		logic [8:0]        side_symbol;
		logic              sign_flag;
		logic [23:0]       nan_payload;
		logic [4:0]        extra_count;
		logic [22:0]       extra_bits;
	} split_res_t;

endpackage

// ----- rtl/core/fss_classify.sv -----
module fss_classify (
	input  logic [fss_pkg::SAMPLE_W-1:0] sample_bits,
	input  fss_pkg::cfg_t                cfg,
	output fss_pkg::split_res_t          res
);
	import fss_pkg::*;

	logic [7:0]        biased;
	logic [22:0]       mant;
	logic              sign;
	logic [4:0]        lz;
	logic [22:0]       frac;
	logic signed [9:0] e;
	logic signed [9:0] shift;
	logic signed [9:0] avail_raw;
	logic signed [9:0] cap;
	logic signed [9:0] avail_min;
	logic [4:0]        avail;
	logic              in_fast;
	logic [4:0]        sh5;
	logic [23:0]       mag;
	logic signed [5:0] resid;
	logic [22:0]       tail;
	logic [22:0]       mask;
	logic signed [9:0] sym;

	assign biased = sample_bits[30:23];
	assign mant   = sample_bits[22:0];
	assign sign   = sample_bits[31];

	// Leading-zero count of the denormal mantissa
	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (mant[i]) begin
				lz = 5'(22 - i);
			end
		end
	end

	// Normalize: exponent and fraction without the implicit one
	always_comb begin
		if (biased == 8'd0) begin
			e    = -EXP_BIAS - $signed({5'b0, lz});
			frac = 23'(mant << (lz + 5'd1));
		end else begin
			e    = $signed({2'b0, biased}) - EXP_BIAS;
			frac = mant;
		end
	end

	// Shift and residual budget
	assign shift     = e + $signed({5'b0, cfg.exponent_span})
	                   - $signed({cfg.top_exponent[8], cfg.top_exponent});
	assign avail_raw = e - $signed({cfg.floor_exponent[8], cfg.floor_exponent});
	assign cap       = MANT_BITS - $signed({5'b0, cfg.shift_trim});
	assign avail_min = (cap < avail_raw) ? cap : avail_raw;
	assign avail     = (avail_min < 10'sd0) ? 5'd0 : avail_min[4:0];
	assign in_fast   = (shift >= 10'sd0) && (shift <= MANT_BITS);
	assign sh5       = shift[4:0];

	assign mag   = {1'b1, frac} >> (MANT_BITS_U - sh5);
	assign resid = $signed({1'b0, avail}) - $signed({1'b0, sh5});
	assign tail  = frac >> (MANT_BITS_U - avail);
	assign mask  = ~(23'h7fffff << resid[4:0]);
	assign sym   = e + SYM_OFFSET;

	// Classify and build the result word
	always_comb begin
		res = '0;
		if (biased == EXP_ALL_ONES) begin
			res.sample_kind = KIND_INF_NAN;
			res.side_symbol = SYM_INF_NAN;
			res.nan_payload = {mant, sign};
		end else if (biased == 8'd0 && mant == 23'd0) begin
			res.sample_kind = KIND_ZERO;
			res.sign_flag   = sign;
		end else if (in_fast) begin
			res.sample_kind = KIND_FAST;
			res.int_value   = sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			if (resid > 6'sd0) begin
				res.extra_count = resid[4:0];
				res.extra_bits  = tail & mask;
			end
		end else begin
			res.sample_kind = KIND_ESCAPE;
			res.side_symbol = sym[8:0];
			res.sign_flag   = sign;
			res.extra_count = avail;
			res.extra_bits  = tail;
		end
	end

endmodule

// ----- rtl/core/float_sample_split.sv -----
// float_sample_split: splits IEEE single-precision samples into coder pieces.
// Input stream s_*: one word per sample, s_tdata holds the raw 32-bit pattern.
// Output stream m_*: one word per sample, in order. m_tuser is the sample
// kind (fast path, escape, zero, inf/NaN); m_tdata packs the integer value,
// side symbol, sign, NaN payload, residual count and residual bits.
// Config port cfg_*: cfg_index selects exponent span, floor exponent, top
// exponent or shift trim; cfg_ready is always high. Write only while idle.
// Path: an accepted word is held in the input register, classified by the
// combinational stage, and captured in the result register that drives m_*.
// Throughput: one sample per cycle while m_tready stays high, set by the
// single combinational stage (leading-zero count, barrel shifts, exponent
// adds) between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// holds behind it; s_tready drops only when both are full.
// Reset (arst_n low) empties both stages and restores the register defaults.
`include "float_sample_split_defines.svh"

module float_sample_split (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample_bits[31:0]
	input  logic [fss_pkg::SAMPLE_W-1:0]    s_tdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// int_value[24:0], side_symbol[33:25], sign_flag[34], nan_payload[58:35],
	// extra_count[63:59], extra_bits[86:64], zero pad[87]
	output logic [fss_pkg::RESULT_W-1:0]    m_tdata,
	// sample_kind[1:0]
	output logic [1:0]                      m_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fss_pkg::*;

	cfg_t        cfg_q;
	logic [31:0] sample_s1;
	logic        valid_s1;
	split_res_t  res_comb;
	split_res_t  res_s2;
	logic        valid_s2;
	logic        advance;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exponent_span  <= 5'd0;
			cfg_q.floor_exponent <= FLOOR_RESET;
			cfg_q.top_exponent   <= 9'd0;
			cfg_q.shift_trim     <= 5'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_EXPONENT_SPAN:  cfg_q.exponent_span  <= cfg_data[4:0];
				CFG_FLOOR_EXPONENT: cfg_q.floor_exponent <= cfg_data;
				CFG_TOP_EXPONENT:   cfg_q.top_exponent   <= cfg_data;
				CFG_SHIFT_TRIM:     cfg_q.shift_trim     <= cfg_data[4:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// Advance the pipe whenever the result register is free or drains
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata;
		end
	end

	fss_classify u_classify (
		.sample_bits (sample_s1),
		.cfg         (cfg_q),
		.res         (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.sample_kind;
	assign m_tdata  = {1'b0, res_s2.extra_bits, res_s2.extra_count, res_s2.nan_payload,
	                   res_s2.sign_flag, res_s2.side_symbol, res_s2.int_value};

	// Checks on the pipeline and result encoding
	`FSS_ASSERT_NEXT(a_load_s1, clk, arst_n, s_tvalid && s_tready, valid_s1,
		"accepted word did not reach the input register")
	`FSS_ASSERT_NEXT(a_load_s2, clk, arst_n, valid_s1 && advance, valid_s2,
		"input register word did not reach the result register")
	`FSS_ASSERT_SAME(a_int_fast, clk, arst_n, m_tvalid && m_tuser != KIND_FAST,
		m_tdata[24:0] == 25'd0, "integer value set outside the fast path")
	`FSS_ASSERT_SAME(a_inf_nan, clk, arst_n, m_tvalid && m_tuser == KIND_INF_NAN,
		m_tdata[33:25] == SYM_INF_NAN && m_tdata[63:59] == 5'd0,
		"inf/NaN word carries wrong symbol or residual count")

endmodule
